@@ hw/rtl/srph_pkg.sv @@
// srph_pkg: shared types, constants and codes for the region pair histogram
// used by srph_front, srph_fifo, srph_back and the top level
// no dependencies
`timescale 1ns / 1ps

package srph_pkg;

  // table geometry
  localparam int REGIONS    = 71;
  localparam int COUNT_BITS = 48;
  localparam int LABEL_W    = 8;
  localparam int WEIGHT_W   = 16;

  // label folding
  localparam logic [LABEL_W-1:0] LABEL_FOLD_ABOVE = LABEL_W'(100);
  localparam logic [LABEL_W-1:0] LABEL_FOLD_BY    = LABEL_W'(65);

  // symmetric matrix kept as a lower triangle
  localparam int CELLS  = REGIONS * (REGIONS + 1) / 2;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TRI_W  = 2 * LABEL_W;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // input kind codes
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // operation carried through the queue
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_ERROR
  } op_t;

  // one classified transaction
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

endpackage

@@ hw/rtl/symmetric_region_pair_histogram.sv @@
// symmetric_region_pair_histogram: top level, configuration register and
// wiring of front, queue and back
// depends on srph_pkg, srph_front, srph_fifo, srph_back
`timescale 1ns / 1ps

// Symmetric region pair histogram. Each add transaction folds both labels
// (labels above 100 lose 65), and when both lie below 71 it adds one, plus
// the edge weight when use_weights is set, to the saturating 48-bit count
// of the unordered pair; a read transaction returns that count. Out of range
// labels give a result with label_error set and a zero count and change
// nothing. Since the matrix is symmetric only its lower triangle is stored,
// 2556 cells in one single-port-read memory. After reset the block clears
// every cell of that memory with in_ready low; configuration writes are
// taken at any time. In the back end each transaction then goes through a
// registered memory read, then the saturating add, write-back and result
// load, and the next one is not taken until that result is loaded; out of
// range transactions skip the read. A four-entry queue between the input
// stage and the back end absorbs short output stalls.
module symmetric_region_pair_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [srph_pkg::LABEL_W-1:0]      in_first_label,
  input  logic [srph_pkg::LABEL_W-1:0]      in_second_label,
  input  logic [srph_pkg::WEIGHT_W-1:0]     in_edge_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srph_pkg::COUNT_BITS-1:0]   out_cell_count,
  output logic                              out_label_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_use_weights
);

  logic             use_weights_r;
  logic             use_weights_nxt;
  logic             clear_busy;
  logic             push;
  srph_pkg::entry_t push_data;
  logic             fifo_full;
  logic             fifo_empty;
  logic             pop;
  srph_pkg::entry_t head;

  // configuration register
  assign cfg_ready       = 1'b1;
  assign use_weights_nxt = (cfg_valid && cfg_ready) ? cfg_use_weights : use_weights_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_weights_r <= 1'b0;
    end else begin
      use_weights_r <= use_weights_nxt;
    end
  end

  // input stage
  srph_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_first_label  (in_first_label),
    .in_second_label (in_second_label),
    .in_edge_weight  (in_edge_weight),
    .clear_busy      (clear_busy),
    .push            (push),
    .push_data       (push_data),
    .fifo_full       (fifo_full)
  );

  // queue
  srph_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (fifo_empty)
  );

  // memory update and result
  srph_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .use_weights     (use_weights_r),
    .fifo_empty      (fifo_empty),
    .head            (head),
    .pop             (pop),
    .clear_busy      (clear_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_count  (out_cell_count),
    .out_label_error (out_label_error)
  );

endmodule

@@ hw/rtl/srph_front.sv @@
// srph_front: accepts transactions, folds labels, checks range and forms
// the triangle address; one registered stage feeding the queue
// depends on srph_pkg
`timescale 1ns / 1ps

module srph_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [srph_pkg::LABEL_W-1:0]    in_first_label,
  input  logic [srph_pkg::LABEL_W-1:0]    in_second_label,
  input  logic [srph_pkg::WEIGHT_W-1:0]   in_edge_weight,
  input  logic                            clear_busy,
  output logic                            push,
  output srph_pkg::entry_t                push_data,
  input  logic                            fifo_full
);

  logic                            stage_valid_r;
  logic                            stage_valid_nxt;
  srph_pkg::entry_t                stage_entry_r;
  srph_pkg::entry_t                stage_entry_nxt;
  logic [srph_pkg::LABEL_W-1:0]    map_a;
  logic [srph_pkg::LABEL_W-1:0]    map_b;
  logic [srph_pkg::LABEL_W-1:0]    lo;
  logic [srph_pkg::LABEL_W-1:0]    hi;
  logic [srph_pkg::TRI_W-1:0]      hi_ext;
  logic [srph_pkg::TRI_W-1:0]      tri_idx;
  logic                            in_range;
  logic                            accept;

  // label folding and range check
  always_comb begin
    map_a = (in_first_label > srph_pkg::LABEL_FOLD_ABOVE) ?
            in_first_label - srph_pkg::LABEL_FOLD_BY : in_first_label;
    map_b = (in_second_label > srph_pkg::LABEL_FOLD_ABOVE) ?
            in_second_label - srph_pkg::LABEL_FOLD_BY : in_second_label;
    in_range = ({1'b0, map_a} < (srph_pkg::LABEL_W + 1)'(srph_pkg::REGIONS)) &&
               ({1'b0, map_b} < (srph_pkg::LABEL_W + 1)'(srph_pkg::REGIONS));
  end

  // triangle address hi*(hi+1)/2 + lo
  always_comb begin
    lo      = (map_a < map_b) ? map_a : map_b;
    hi      = (map_a < map_b) ? map_b : map_a;
    hi_ext  = srph_pkg::TRI_W'(hi);
    tri_idx = ((hi_ext * (hi_ext + srph_pkg::TRI_W'(1))) >> 1) + srph_pkg::TRI_W'(lo);
  end

  // stage handshake
  assign push     = stage_valid_r && !fifo_full;
  assign in_ready = !clear_busy && (!stage_valid_r || !fifo_full);
  assign accept   = in_valid && in_ready;
  assign push_data = stage_entry_r;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_entry_nxt = stage_entry_r;
    if (push) begin
      stage_valid_nxt = 1'b0;
    end
    if (accept) begin
      stage_valid_nxt        = 1'b1;
      stage_entry_nxt.addr   = srph_pkg::ADDR_W'(tri_idx);
      stage_entry_nxt.weight = in_edge_weight;
      if (!in_range) begin
        stage_entry_nxt.op = srph_pkg::OP_ERROR;
      end else if (in_kind == srph_pkg::KIND_READ) begin
        stage_entry_nxt.op = srph_pkg::OP_READ;
      end else begin
        stage_entry_nxt.op = srph_pkg::OP_ADD;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_entry_r <= stage_entry_nxt;
  end

endmodule

@@ hw/rtl/srph_fifo.sv @@
// srph_fifo: short queue of classified transactions between front and back
// depends on srph_pkg
`timescale 1ns / 1ps

module srph_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srph_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output srph_pkg::entry_t pop_data,
  output logic             empty
);

  srph_pkg::entry_t                  slots_r [srph_pkg::FIFO_DEPTH];
  logic [srph_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [srph_pkg::FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [srph_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [srph_pkg::FIFO_PTR_W-1:0]   rd_ptr_nxt;
  logic [srph_pkg::FIFO_CNT_W-1:0]   count_r;
  logic [srph_pkg::FIFO_CNT_W-1:0]   count_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign full     = (count_r == srph_pkg::FIFO_CNT_W'(srph_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == srph_pkg::FIFO_PTR_W'(srph_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + srph_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == srph_pkg::FIFO_PTR_W'(srph_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + srph_pkg::FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + srph_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - srph_pkg::FIFO_CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= srph_pkg::FIFO_CNT_W'(srph_pkg::FIFO_DEPTH))
    else $error("queue fill count out of range");

  // pointers coincide whenever the queue is empty or full
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/srph_back.sv @@
// srph_back: count memory, clearing pass, read-modify-write sequencer and
// output register
// depends on srph_pkg
`timescale 1ns / 1ps

module srph_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              use_weights,
  input  logic                              fifo_empty,
  input  srph_pkg::entry_t                  head,
  output logic                              pop,
  output logic                              clear_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srph_pkg::COUNT_BITS-1:0]   out_cell_count,
  output logic                              out_label_error
);

  logic [srph_pkg::COUNT_BITS-1:0]   count_mem_r [srph_pkg::CELLS];
  srph_pkg::back_state_t             state_r;
  srph_pkg::back_state_t             state_nxt;
  logic [srph_pkg::ADDR_W-1:0]       clr_addr_r;
  logic [srph_pkg::ADDR_W-1:0]       clr_addr_nxt;
  srph_pkg::op_t                     op_r;
  logic [srph_pkg::ADDR_W-1:0]       addr_r;
  logic [srph_pkg::WEIGHT_W-1:0]     weight_r;
  logic [srph_pkg::COUNT_BITS-1:0]   rd_data_r;
  logic                              rd_en;
  logic                              mem_we;
  logic [srph_pkg::ADDR_W-1:0]       mem_waddr;
  logic [srph_pkg::COUNT_BITS-1:0]   mem_wdata;
  logic [srph_pkg::WEIGHT_W:0]       inc;
  logic [srph_pkg::COUNT_BITS:0]     sum;
  logic [srph_pkg::COUNT_BITS-1:0]   sat_sum;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [srph_pkg::COUNT_BITS-1:0]   out_count_r;
  logic                              out_err_r;
  logic                              out_free;
  logic                              load_out;
  logic [srph_pkg::COUNT_BITS-1:0]   load_count;
  logic                              load_err;

  assign out_free        = !out_valid_r || out_ready;
  assign clear_busy      = (state_r == srph_pkg::ST_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_cell_count  = out_count_r;
  assign out_label_error = out_err_r;

  // saturating increment of the cell just read
  always_comb begin
    inc = (srph_pkg::WEIGHT_W + 1)'(use_weights ? weight_r : '0) +
          (srph_pkg::WEIGHT_W + 1)'(1);
    sum = {1'b0, rd_data_r} + (srph_pkg::COUNT_BITS + 1)'(inc);
    sat_sum = sum[srph_pkg::COUNT_BITS] ? '1 : sum[srph_pkg::COUNT_BITS-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    pop          = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = sat_sum;
    load_out     = 1'b0;
    load_count   = '0;
    load_err     = 1'b0;
    case (state_r)
      srph_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == srph_pkg::ADDR_W'(srph_pkg::CELLS - 1)) begin
          state_nxt = srph_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + srph_pkg::ADDR_W'(1);
        end
      end
      srph_pkg::ST_IDLE: begin
        if (!fifo_empty && out_free) begin
          pop = 1'b1;
          if (head.op == srph_pkg::OP_ERROR) begin
            load_out = 1'b1;
            load_err = 1'b1;
          end else begin
            rd_en     = 1'b1;
            state_nxt = srph_pkg::ST_UPDATE;
          end
        end
      end
      srph_pkg::ST_UPDATE: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_count = (op_r == srph_pkg::OP_ADD) ? sat_sum : rd_data_r;
          mem_we     = (op_r == srph_pkg::OP_ADD);
          state_nxt  = srph_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srph_pkg::ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srph_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      op_r     <= head.op;
      addr_r   <= head.addr;
      weight_r <= head.weight;
    end
    if (load_out) begin
      out_count_r <= load_count;
      out_err_r   <= load_err;
    end
  end

  // count memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= count_mem_r[head.addr];
    end
  end

`ifndef SYNTHESIS
  // no result leaves while the memory is being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srph_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("result produced during clearing pass");

  // an update never wraps a count downward
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srph_pkg::ST_UPDATE && mem_we) |-> (mem_wdata > rd_data_r ||
      rd_data_r == '1))
    else $error("count update wrapped");

  // read data holds while the result waits for the output slot
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srph_pkg::ST_UPDATE && !out_free) |=> $stable(rd_data_r))
    else $error("read data changed during stall");

  // a flagged result carries a zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_count_r == '0))
    else $error("error result with nonzero count");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench for symmetric_region_pair_histogram: directed table, then random edge traffic
// checked transaction by transaction against a local model of the pair table
// depends on srph_pkg and symmetric_region_pair_histogram
`timescale 1ns / 1ps

module testbench;

  // one result as the block reports it
  typedef struct packed {
    logic [srph_pkg::COUNT_BITS-1:0] count;
    logic                            err;
  } cell_result_t;

  // one row of the directed table; fixed_* holds the typed-in result where known
  typedef struct packed {
    logic                            set_cfg;
    logic                            cfg_value;
    logic                            kind;
    logic [srph_pkg::LABEL_W-1:0]    first;
    logic [srph_pkg::LABEL_W-1:0]    second;
    logic [srph_pkg::WEIGHT_W-1:0]   weight;
    logic                            typed;
    logic [srph_pkg::COUNT_BITS-1:0] fixed_count;
    logic                            fixed_err;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 300;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_kind;
  logic [srph_pkg::LABEL_W-1:0]    in_first_label;
  logic [srph_pkg::LABEL_W-1:0]    in_second_label;
  logic [srph_pkg::WEIGHT_W-1:0]   in_edge_weight;
  logic                            out_valid;
  logic                            out_ready;
  logic [srph_pkg::COUNT_BITS-1:0] out_cell_count;
  logic                            out_label_error;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_use_weights;

  // local copy of the table and the weighting switch
  logic [srph_pkg::COUNT_BITS-1:0] pair_table [srph_pkg::REGIONS][srph_pkg::REGIONS];
  logic                            weights_on;
  cell_result_t                    pending_cells [$];
  int                              mismatch_count = 0;
  int                              in_quiet = 0;
  int                              out_quiet = 0;
  int                              out_stall_left = 0;

  // labels that keep coming back so cells build up
  logic [srph_pkg::LABEL_W-1:0] hot_labels [8] =
    '{8'd0, 8'd1, 8'd2, 8'd36, 8'd70, 8'd101, 8'd134, 8'd135};

  // directed rows: fresh reads, out of range labels, folding, mirroring, weighting
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd0,   8'd0,   16'h0000, 1'b1, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd70,  8'd70,  16'h0000, 1'b1, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd135, 8'd101, 16'h0000, 1'b1, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd255, 8'd0,   16'h0000, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd71,  8'd5,   16'hffff, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd5,   8'd100, 16'hffff, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd136, 8'd0,   16'h0000, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd255, 8'd255, 16'hffff, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd0,   8'd0,   16'hffff, 1'b1, 48'd1, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd70,  8'd0,   16'hffff, 1'b1, 48'd1, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd0,   8'd70,  16'h0000, 1'b1, 48'd1, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd101, 8'd36,  16'h0000, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd36,  8'd101, 16'h0000, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd135, 8'd134, 16'h5555, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd99,  8'd0,   16'h0000, 1'b1, 48'd0, 1'b1},
    '{1'b1, 1'b1, srph_pkg::KIND_ADD,  8'd1,   8'd2,   16'hffff, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd2,   8'd1,   16'h0000, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd1,   8'd2,   16'h0000, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd0,   8'd0,   16'hffff, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd200, 8'd3,   16'hffff, 1'b1, 48'd0, 1'b1},
    '{1'b0, 1'b0, srph_pkg::KIND_READ, 8'd70,  8'd0,   16'h0000, 1'b0, 48'd0, 1'b0},
    '{1'b0, 1'b0, srph_pkg::KIND_ADD,  8'd135, 8'd70,  16'haaaa, 1'b0, 48'd0, 1'b0}
  };

  symmetric_region_pair_histogram dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_first_label  (in_first_label),
    .in_second_label (in_second_label),
    .in_edge_weight  (in_edge_weight),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_count  (out_cell_count),
    .out_label_error (out_label_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_use_weights (cfg_use_weights)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // labels above 100 drop by 65
  function automatic logic [srph_pkg::LABEL_W-1:0] fold_label(
      input logic [srph_pkg::LABEL_W-1:0] raw);
    return (raw > srph_pkg::LABEL_FOLD_ABOVE) ? raw - srph_pkg::LABEL_FOLD_BY : raw;
  endfunction

  function automatic logic [srph_pkg::COUNT_BITS-1:0] saturate_add(
      input logic [srph_pkg::COUNT_BITS-1:0] cur,
      input logic [srph_pkg::COUNT_BITS-1:0] inc);
    logic [srph_pkg::COUNT_BITS:0] sum;
    sum = {1'b0, cur} + {1'b0, inc};
    return sum[srph_pkg::COUNT_BITS] ? {srph_pkg::COUNT_BITS{1'b1}} :
                                       sum[srph_pkg::COUNT_BITS-1:0];
  endfunction

  // applies one edge or read to the local table and returns the cell it reports
  function automatic cell_result_t accumulate_pair(input logic kind,
                                                   input logic [srph_pkg::LABEL_W-1:0] first,
                                                   input logic [srph_pkg::LABEL_W-1:0] second,
                                                   input logic [srph_pkg::WEIGHT_W-1:0] weight);
    logic [srph_pkg::LABEL_W-1:0]    row;
    logic [srph_pkg::LABEL_W-1:0]    col;
    logic [srph_pkg::COUNT_BITS-1:0] inc;
    cell_result_t                    res;
    row = fold_label(first);
    col = fold_label(second);
    if (row >= srph_pkg::REGIONS || col >= srph_pkg::REGIONS) begin
      res.count = '0;
      res.err   = 1'b1;
      return res;
    end
    if (kind == srph_pkg::KIND_ADD) begin
      inc = srph_pkg::COUNT_BITS'(1) +
            (weights_on ? srph_pkg::COUNT_BITS'(weight) : srph_pkg::COUNT_BITS'(0));
      pair_table[row][col] = saturate_add(pair_table[row][col], inc);
      if (row != col) begin
        pair_table[col][row] = saturate_add(pair_table[col][row], inc);
      end
    end
    res.count = pair_table[row][col];
    res.err   = 1'b0;
    return res;
  endfunction

  // gap length: mostly none or short, a few long, now and then a quiet stretch
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly valid labels, many from the hot set, some anywhere in the byte
  function automatic logic [srph_pkg::LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return hot_labels[$urandom_range(0, 7)];
    if (r < 80) begin
      if ($urandom_range(0, 1)) return srph_pkg::LABEL_W'($urandom_range(0, 70));
      return srph_pkg::LABEL_W'($urandom_range(101, 135));
    end
    return srph_pkg::LABEL_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [srph_pkg::COUNT_BITS-1:0] got,
                                 input logic [srph_pkg::COUNT_BITS-1:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // one input transaction; the expectation is recorded when it is accepted
  task automatic send_item(input logic kind, input logic [srph_pkg::LABEL_W-1:0] first,
                           input logic [srph_pkg::LABEL_W-1:0] second,
                           input logic [srph_pkg::WEIGHT_W-1:0] weight,
                           input logic typed, input cell_result_t fixed);
    int           gap;
    cell_result_t res;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_first_label  <= first;
    in_second_label <= second;
    in_edge_weight  <= weight;
    do @(posedge clk); while (!in_ready);
    res = accumulate_pair(kind, first, second, weight);
    pending_cells.push_back(typed ? fixed : res);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  task automatic write_weights(input logic value);
    cfg_use_weights <= value;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    weights_on = value;
  endtask

  // result side: random stalls, in-order compare
  always @(posedge clk) begin : result_check
    cell_result_t want;
    int           stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_cells.size() == 0) begin
          report_mismatch("result with nothing pending, count", out_cell_count, '0);
        end else begin
          want = pending_cells.pop_front();
          if (out_cell_count !== want.count)
            report_mismatch("cell_count", out_cell_count, want.count);
          if (out_label_error !== want.err)
            report_mismatch("label_error", srph_pkg::COUNT_BITS'(out_label_error),
                            srph_pkg::COUNT_BITS'(want.err));
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall = pick_gap(out_quiet);
        if (stall > 0) begin
          out_stall_left = stall - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // stimulus: reset, directed table, random phases, final drain
  initial begin : stimulus
    logic                          phase_weights [RANDOM_PHASES];
    cell_result_t                  fixed;
    cell_result_t                  none;
    logic                          kind;
    logic [srph_pkg::LABEL_W-1:0]  first;
    logic [srph_pkg::LABEL_W-1:0]  second;
    logic [srph_pkg::WEIGHT_W-1:0] weight;
    logic [srph_pkg::LABEL_W-1:0]  last_first;
    logic [srph_pkg::LABEL_W-1:0]  last_second;
    int                            r;
    phase_weights   = '{1'b0, 1'b1, 1'b0, 1'b1};
    none            = '0;
    last_first      = '0;
    last_second     = '0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = srph_pkg::KIND_ADD;
    in_first_label  = '0;
    in_second_label = '0;
    in_edge_weight  = '0;
    cfg_valid       = 1'b0;
    cfg_use_weights = 1'b0;
    weights_on      = 1'b0;
    for (int i = 0; i < srph_pkg::REGIONS; i++)
      for (int j = 0; j < srph_pkg::REGIONS; j++)
        pair_table[i][j] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cfg) begin
        drain_results();
        write_weights(directed_rows[i].cfg_value);
      end
      fixed.count = directed_rows[i].fixed_count;
      fixed.err   = directed_rows[i].fixed_err;
      send_item(directed_rows[i].kind, directed_rows[i].first, directed_rows[i].second,
                directed_rows[i].weight, directed_rows[i].typed, fixed);
    end

    // random phases, weighting switched between them
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      write_weights(phase_weights[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind   = ($urandom_range(0, 99) < 65) ? srph_pkg::KIND_ADD : srph_pkg::KIND_READ;
        first  = pick_label();
        second = pick_label();
        // reads often look back at the last edge, mirrored
        if (kind == srph_pkg::KIND_READ && $urandom_range(0, 1)) begin
          first  = last_second;
          second = last_first;
        end
        r = $urandom_range(0, 99);
        if (r < 20)      weight = '0;
        else if (r < 35) weight = '1;
        else             weight = srph_pkg::WEIGHT_W'($urandom_range(0, 65535));
        if (kind == srph_pkg::KIND_ADD) begin
          last_first  = first;
          last_second = second;
        end
        send_item(kind, first, second, weight, 1'b0, none);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_cells.size() == 0) begin
      $display("symmetric_region_pair_histogram verification clean");
    end else begin
      $display("symmetric_region_pair_histogram verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("symmetric_region_pair_histogram verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/srph_pkg.sv
hw/rtl/srph_front.sv
hw/rtl/srph_fifo.sv
hw/rtl/srph_back.sv
hw/rtl/symmetric_region_pair_histogram.sv
tb/testbench.sv
